[src/bfp_pkg.sv]
// ----------------------------------------------------------------------------
// Burst framer package
// Shared widths, register indexes and the item record between the front end
// and the emit sequencer.
// ----------------------------------------------------------------------------
package bfp_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int LENGTH_WIDTH = 24;
   localparam int TAG_WIDTH    = 16;
   localparam int MULT_WIDTH   = 16;
   localparam int MULT_FRAC    = 8;
   localparam int PAD_WIDTH    = 5;
   localparam int PROD_WIDTH   = TAG_WIDTH + MULT_WIDTH;

   localparam logic [MULT_WIDTH-1:0] MULT_RESET = MULT_WIDTH'(256);

   typedef enum logic [1:0] {
      CSR_LENGTH_MULT  = 2'd0,
      CSR_FRONT_PAD    = 2'd1,
      CSR_REAR_PAD     = 2'd2,
      CSR_DROP_OUTSIDE = 2'd3
   } csr_index_type;

   // One accepted sample and what it does to the burst.
   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] sample_i;
      logic [SAMPLE_WIDTH-1:0] sample_q;
      logic                    opens;    // sample opens a burst
      logic                    closes;   // burst ends after this sample
      logic                    ign;      // ignore tag of the opening sample
      logic                    active;   // inside a burst
   } item_type;

endpackage

[src/burst_framer_with_padding_top.sv]
// ----------------------------------------------------------------------------
// Burst framer with zero padding
// Opens a burst on a length-tagged sample, frames it with front and rear
// zero pads and start/end of burst marks; passes or drops other samples.
//
//   channel  dir  data                                     user / last
//   req_     in   tdata[47:0]: i, q, tag_length             tuser: len tag, ign tag
//   rsp_     out  tdata[31:0]: out_i, out_q                 tuser: sob, eob, ign,
//                                                           active; tlast: last
//   csr_     in   csr_index[1:0], csr_data[15:0]           -
//
// One result per cycle while rsp_tready takes them. A sample gives one result,
// an opening sample adds front_pad_count pads and a closing one rear_pad_count;
// the emit sequencer holds the input stalled while it plays out the pads.
// Burst length is computed with one 16x16 multiply at input acceptance.
// Synchronous active-high reset clears burst state and resets the control registers.
// The result register lets a new sample in while a result waits.
// ----------------------------------------------------------------------------
module burst_framer_with_padding_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // sample_i, sample_q, tag_length
   input  logic [1:0]  req_tuser,  // has_length_tag, has_ignore_tag
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // out_i, out_q
   output logic [3:0]  rsp_tuser,  // start_of_burst, end_of_burst,
                                   // ignore_mark, burst_active
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import bfp_pkg::*;

   logic [MULT_WIDTH-1:0]   mult_ff;
   logic [PAD_WIDTH-1:0]    front_pad_ff, rear_pad_ff;
   logic                    drop_outside_ff;
   logic                    inside_ff, inside_in;
   logic [LENGTH_WIDTH-1:0] remaining_ff, remaining_in;

   logic                    accept, load, free;
   logic [TAG_WIDTH-1:0]    tag_length;
   logic [PROD_WIDTH-1:0]   product;
   logic [LENGTH_WIDTH-1:0] burst_len, rem_dec, len_dec;
   logic                    opens, closes;
   item_type                item;

   // no transfers are taken while reset is held
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff         <= MULT_RESET;
         front_pad_ff    <= '0;
         rear_pad_ff     <= '0;
         drop_outside_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_LENGTH_MULT:  mult_ff         <= csr_data;
            CSR_FRONT_PAD:    front_pad_ff    <= csr_data[PAD_WIDTH-1:0];
            CSR_REAR_PAD:     rear_pad_ff     <= csr_data[PAD_WIDTH-1:0];
            CSR_DROP_OUTSIDE: drop_outside_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign tag_length = req_tdata[47:32];
   assign product    = PROD_WIDTH'(tag_length) * PROD_WIDTH'(mult_ff);
   // Q8.8 product shifted down fits the length counter, so never saturates
   assign burst_len  = product[PROD_WIDTH-1:MULT_FRAC];
   assign len_dec    = burst_len - LENGTH_WIDTH'(1);
   assign rem_dec    = remaining_ff - LENGTH_WIDTH'(1);

   assign opens  = !inside_ff && req_tuser[0] && (burst_len != '0);
   assign closes = inside_ff ? (rem_dec == '0) : (opens && (len_dec == '0));

   assign item.sample_i = req_tdata[SAMPLE_WIDTH-1:0];
   assign item.sample_q = req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
   assign item.opens    = opens;
   assign item.closes   = closes;
   assign item.ign      = opens && req_tuser[1];
   assign item.active   = inside_ff || opens;

   assign req_tready = free && !reset;
   assign accept     = req_tvalid && req_tready;
   // dropped samples produce no result and never reach the sequencer
   assign load       = accept && (inside_ff || opens || !drop_outside_ff);

   always_comb begin
      inside_in    = inside_ff;
      remaining_in = remaining_ff;
      if (accept) begin
         if (inside_ff) begin
            remaining_in = rem_dec;
            inside_in    = !closes;
         end else if (opens) begin
            remaining_in = len_dec;
            inside_in    = !closes;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff    <= 1'b0;
         remaining_ff <= '0;
      end else begin
         inside_ff    <= inside_in;
         remaining_ff <= remaining_in;
      end
   end

   bfp_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .item       (item),
      .front_pad  (front_pad_ff),
      .rear_pad   (rear_pad_ff),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef ASSERT_OFF
   a_idle_no_count: assert property (@(posedge clock) disable iff (reset)
      !inside_ff |-> remaining_ff == '0)
      else $error("data count left over outside a burst");

   a_inside_count: assert property (@(posedge clock) disable iff (reset)
      inside_ff |-> remaining_ff != '0)
      else $error("open burst with no data left");

   a_open_loads: assert property (@(posedge clock) disable iff (reset)
      accept && opens |=> inside_ff || $past(closes))
      else $error("opening sample did not open a burst");
`endif

endmodule

[src/bfp_emit.sv]
// ----------------------------------------------------------------------------
// Burst framer emit sequencer
// Holds one item and plays out front pads, the sample and rear pads into
// the result register, one result per cycle while rsp_tready allows.
// ----------------------------------------------------------------------------
module bfp_emit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  bfp_pkg::item_type                 item,
   input  logic [bfp_pkg::PAD_WIDTH-1:0]     front_pad,
   input  logic [bfp_pkg::PAD_WIDTH-1:0]     rear_pad,
   output logic                              free,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [2*bfp_pkg::SAMPLE_WIDTH-1:0] rsp_tdata, // out_i, out_q
   output logic [3:0]                        rsp_tuser, // start_of_burst,
                                                        // end_of_burst,
                                                        // ignore_mark,
                                                        // burst_active
   output logic                              rsp_tlast
);
   import bfp_pkg::*;

   item_type               item_ff;
   logic                   item_valid_ff, item_valid_in;
   logic [PAD_WIDTH-1:0]   front_left_ff, front_left_in;
   logic [PAD_WIDTH-1:0]   rear_left_ff, rear_left_in;
   logic                   data_done_ff, data_done_in;
   logic                   first_ff, first_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2*SAMPLE_WIDTH-1:0] rsp_data_ff;
   logic [3:0]             rsp_user_ff;
   logic                   rsp_last_ff;

   logic                   out_load, step, in_front, in_data, step_last;
   logic [2*SAMPLE_WIDTH-1:0] step_data;
   logic [3:0]             step_user;

   assign out_load  = !rsp_valid_ff || rsp_tready;
   assign step      = item_valid_ff && out_load;
   assign in_front  = front_left_ff != '0;
   assign in_data   = !in_front && !data_done_ff;
   assign step_last = !in_front &&
                      (in_data ? (rear_left_ff == '0) : (rear_left_ff == PAD_WIDTH'(1)));
   assign free      = !item_valid_ff || (step && step_last);

   assign step_data = in_data ? {item_ff.sample_q, item_ff.sample_i} : '0;
   assign step_user = {item_ff.active,
                       first_ff & item_ff.opens & item_ff.ign,
                       item_ff.closes & step_last,
                       first_ff & item_ff.opens};

   always_comb begin
      item_valid_in = item_valid_ff;
      front_left_in = front_left_ff;
      rear_left_in  = rear_left_ff;
      data_done_in  = data_done_ff;
      first_in      = first_ff;
      if (step) begin
         first_in = 1'b0;
         if (in_front) begin
            front_left_in = front_left_ff - PAD_WIDTH'(1);
         end else if (in_data) begin
            data_done_in = 1'b1;
         end else begin
            rear_left_in = rear_left_ff - PAD_WIDTH'(1);
         end
         if (step_last) begin
            item_valid_in = 1'b0;
         end
      end
      // load only happens when free, so it wins over the final step
      if (load) begin
         item_valid_in = 1'b1;
         front_left_in = item.opens  ? front_pad : '0;
         rear_left_in  = item.closes ? rear_pad  : '0;
         data_done_in  = 1'b0;
         first_in      = 1'b1;
      end
   end

   assign rsp_valid_in = step ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         front_left_ff <= '0;
         rear_left_ff  <= '0;
         data_done_ff  <= 1'b0;
         first_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         front_left_ff <= front_left_in;
         rear_left_ff  <= rear_left_in;
         data_done_ff  <= data_done_in;
         first_ff      <= first_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
      if (step) begin
         rsp_data_ff <= step_data;
         rsp_user_ff <= step_user;
         rsp_last_ff <= step_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   a_sob_in_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[3])
      else $error("start of burst outside a burst");

   a_ign_on_sob: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[0])
      else $error("ignore mark away from start of burst");

   a_eob_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("end of burst not on the last result of its sample");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("item loaded over a busy sequencer");
`endif

endmodule
